// ===== hdl/ssf_pkg.sv =====
// Shared types, widths and the operation table of the two-state filter step.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ssf_pkg;

	localparam int SAMPLE_W            = 32;
	localparam int COEF_W              = 24;
	localparam int PROD_W              = SAMPLE_W + COEF_W;
	localparam int ACC_W               = PROD_W + 2;
	localparam int FRAC_SHIFT          = 22;
	localparam int CFG_IDX_W           = 4;
	localparam int NUM_REGS            = 8;
	localparam int SEL_W               = $clog2(NUM_REGS);
	localparam int STEP_W              = 4;
	localparam int DEFAULT_STATE_COUNT = 2;

	typedef logic [SEL_W-1:0] coef_sel_t;

	// Register indexes on the configuration channel
	localparam coef_sel_t REG_A11 = 3'd0;
	localparam coef_sel_t REG_A12 = 3'd1;
	localparam coef_sel_t REG_A21 = 3'd2;
	localparam coef_sel_t REG_A22 = 3'd3;
	localparam coef_sel_t REG_B1  = 3'd4;
	localparam coef_sel_t REG_B2  = 3'd5;
	localparam coef_sel_t REG_C1  = 3'd6;
	localparam coef_sel_t REG_C2  = 3'd7;

	typedef enum logic [1:0] {
		OPD_X0,
		OPD_X1,
		OPD_U
	} opd_sel_t;

	typedef enum logic [1:0] {
		DST_YB,
		DST_X0,
		DST_X1,
		DST_YA
	} dst_t;

	typedef struct packed {
		coef_sel_t coef;
		opd_sel_t  opd;
		logic      first;
		logic      last;
		dst_t      dst;
	} op_t;

	typedef struct packed {
		logic                       valid;
		logic signed [COEF_W-1:0]   coef;
		logic signed [SAMPLE_W-1:0] opd;
		logic                       first;
		logic                       last;
		dst_t                       dst;
	} mac_req_t;

	typedef struct packed {
		logic                       valid;
		dst_t                       dst;
		logic signed [SAMPLE_W-1:0] value;
	} mac_res_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] y_before;
		logic signed [SAMPLE_W-1:0] y_after;
	} out_beat_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [COEF_W-1:0]    wdata;
	} cfg_beat_t;

	function automatic op_t mk_op(coef_sel_t c, opd_sel_t o, logic f, logic l, dst_t d);
		op_t r;
		r.coef  = c;
		r.opd   = o;
		r.first = f;
		r.last  = l;
		r.dst   = d;
		return r;
	endfunction

	// Product sequence of one sample: y_before, new state rows, y_after.
	function automatic op_t op_decode(logic [STEP_W-1:0] step, logic two_state);
		op_t r;
		r = mk_op(REG_C1, OPD_X0, 1'b1, 1'b1, DST_YB);
		if (two_state) begin
			case (step)
				4'd0: r = mk_op(REG_C1,  OPD_X0, 1'b1, 1'b0, DST_YB);
				4'd1: r = mk_op(REG_C2,  OPD_X1, 1'b0, 1'b1, DST_YB);
				4'd2: r = mk_op(REG_A11, OPD_X0, 1'b1, 1'b0, DST_X0);
				4'd3: r = mk_op(REG_A12, OPD_X1, 1'b0, 1'b0, DST_X0);
				4'd4: r = mk_op(REG_B1,  OPD_U,  1'b0, 1'b1, DST_X0);
				4'd5: r = mk_op(REG_A21, OPD_X0, 1'b1, 1'b0, DST_X1);
				4'd6: r = mk_op(REG_A22, OPD_X1, 1'b0, 1'b0, DST_X1);
				4'd7: r = mk_op(REG_B2,  OPD_U,  1'b0, 1'b1, DST_X1);
				4'd8: r = mk_op(REG_C1,  OPD_X0, 1'b1, 1'b0, DST_YA);
				4'd9: r = mk_op(REG_C2,  OPD_X1, 1'b0, 1'b1, DST_YA);
				default: r = mk_op(REG_C1, OPD_X0, 1'b1, 1'b1, DST_YB);
			endcase
		end else begin
			case (step)
				4'd0: r = mk_op(REG_C1,  OPD_X0, 1'b1, 1'b1, DST_YB);
				4'd1: r = mk_op(REG_A11, OPD_X0, 1'b1, 1'b0, DST_X0);
				4'd2: r = mk_op(REG_B1,  OPD_U,  1'b0, 1'b1, DST_X0);
				4'd3: r = mk_op(REG_C1,  OPD_X0, 1'b1, 1'b1, DST_YA);
				default: r = mk_op(REG_C1, OPD_X0, 1'b1, 1'b1, DST_YB);
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ssf_chan_if.sv =====
// Valid/ready channel carrying one payload struct per beat.
// Payload types come from ssf_pkg at the point of instantiation.
`timescale 1ns / 1ps
`default_nettype none
interface ssf_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/state_space_filter_step.sv =====
// Top level of the two-state discrete state-space filter step.
// Depends on ssf_pkg, ssf_chan_if, ssf_coef_regs and ssf_mac.
//
//   channel   role    payload                          beat meaning
//   samples   sink    sample_in  (s32 Q16.16)          one input sample u
//   results   source  y_before, y_after (s32 Q16.16)   C.x before and after update
//   cfg       sink    index (4b), wdata (s24 Q2.22)    write one coefficient
//
// A new sample is taken only after the previous one has left the sequencer: a
// sequencer feeds the single 24x32 MAC one product a cycle while in its run state,
// and waits out the MAC latency before the state commits and
// again before y_after is known. The result sits in an output register, so the
// next sample is taken while the previous result waits; only a second finished
// result stalls the sequencer. Reset clears the state vector and all
// coefficients; cfg is always ready and writes beyond index 7 are dropped.
`timescale 1ns / 1ps
`default_nettype none
module state_space_filter_step #(
	parameter int STATE_COUNT = ssf_pkg::DEFAULT_STATE_COUNT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssf_chan_if.sink   samples,
	ssf_chan_if.source results,
	ssf_chan_if.sink   cfg
);
	import ssf_pkg::*;

	localparam logic TWO_STATE = (STATE_COUNT == 2);
	// last product before the state commits, and the last product of a sample
	localparam logic [STEP_W-1:0] LAST_PRE  = TWO_STATE ? 4'd7 : 4'd2;
	localparam logic [STEP_W-1:0] LAST_STEP = TWO_STATE ? 4'd9 : 4'd3;
	localparam dst_t COMMIT_DST = TWO_STATE ? DST_X1 : DST_X0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT_X,
		ST_WAIT_Y,
		ST_HOLD
	} seq_state_t;

	seq_state_t                 state_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [SAMPLE_W-1:0] u_q;
	logic signed [SAMPLE_W-1:0] x0_q, x1_q, nx0_q;
	logic signed [SAMPLE_W-1:0] yb_q, ya_q;
	out_beat_t                  out_q;
	logic                       out_vld_q;

	op_t                        op_c;
	coef_sel_t                  sel_c;
	logic signed [COEF_W-1:0]   coef_c;
	mac_req_t                   req_c;
	mac_res_t                   res_c;
	logic                       out_free_c;
	logic                       out_load_c;

	ssf_coef_regs u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sel    (sel_c),
		.coef   (coef_c)
	);

	ssf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_c),
		.res    (res_c)
	);

	// decode the current step into coefficient, operand and accumulator control
	assign op_c  = op_decode(step_q, TWO_STATE);
	assign sel_c = op_c.coef;

	always_comb begin
		req_c.valid = (state_q == ST_RUN);
		req_c.coef  = coef_c;
		req_c.first = op_c.first;
		req_c.last  = op_c.last;
		req_c.dst   = op_c.dst;
		case (op_c.opd)
			OPD_X0:  req_c.opd = x0_q;
			OPD_X1:  req_c.opd = x1_q;
			OPD_U:   req_c.opd = u_q;
			default: req_c.opd = x0_q;
		endcase
	end

	assign samples.ready   = (state_q == ST_IDLE);
	assign results.valid   = out_vld_q;
	assign results.payload = out_q;
	assign out_free_c      = !out_vld_q || results.ready;
	// a finished result moves into the output register this cycle
	assign out_load_c      = out_free_c &&
		((state_q == ST_WAIT_Y && res_c.valid && res_c.dst == DST_YA) ||
		 (state_q == ST_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			u_q       <= '0;
			x0_q      <= '0;
			x1_q      <= '0;
			nx0_q     <= '0;
			yb_q      <= '0;
			ya_q      <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// drop the output beat once taken, unless a new one loads below
			if (results.ready && !out_load_c) out_vld_q <= 1'b0;

			// hold partial results as the MAC hands them back
			if (res_c.valid && res_c.dst == DST_YB) yb_q  <= res_c.value;
			if (res_c.valid && res_c.dst == DST_X0) nx0_q <= res_c.value;

			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						u_q     <= samples.payload.sample_in;
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_PRE)  state_q <= ST_WAIT_X;
					if (step_q == LAST_STEP) state_q <= ST_WAIT_Y;
				end
				ST_WAIT_X: begin
					// both rows used the old state; commit them together
					if (res_c.valid && res_c.dst == COMMIT_DST) begin
						if (TWO_STATE) begin
							x0_q <= nx0_q;
							x1_q <= res_c.value;
						end else begin
							x0_q <= res_c.value;
						end
						state_q <= ST_RUN;
					end
				end
				ST_WAIT_Y: begin
					if (res_c.valid && res_c.dst == DST_YA) begin
						if (out_free_c) begin
							out_q.y_before <= yb_q;
							out_q.y_after  <= res_c.value;
							out_vld_q      <= 1'b1;
							state_q        <= ST_IDLE;
						end else begin
							ya_q    <= res_c.value;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					// previous result still unclaimed: stall until it leaves
					if (out_free_c) begin
						out_q.y_before <= yb_q;
						out_q.y_after  <= ya_q;
						out_vld_q      <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/ssf_coef_regs.sv =====
// Coefficient register file: A, B and C in Q2.22, written over the config channel.
// Depends on ssf_pkg and ssf_chan_if.
`timescale 1ns / 1ps
`default_nettype none
module ssf_coef_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	ssf_chan_if.sink                                cfg,
	input  wire ssf_pkg::coef_sel_t                 sel,
	output logic signed [ssf_pkg::COEF_W-1:0]       coef
);
	import ssf_pkg::*;

	logic signed [COEF_W-1:0] coef_q [NUM_REGS];

	assign cfg.ready = 1'b1;

	// drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) coef_q[i] <= '0;
		end else if (cfg.valid && (cfg.payload.index < CFG_IDX_W'(NUM_REGS))) begin
			coef_q[cfg.payload.index[SEL_W-1:0]] <= cfg.payload.wdata;
		end
	end

	assign coef = coef_q[sel];
endmodule
`default_nettype wire

// ===== hdl/ssf_mac.sv =====
// Shared multiply-accumulate unit: 24x32 product, 58-bit sum, round and saturate.
// Depends on ssf_pkg. Product, accumulator and result are registered in turn.
`timescale 1ns / 1ps
`default_nettype none
module ssf_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ssf_pkg::mac_req_t req,
	output ssf_pkg::mac_res_t      res
);
	import ssf_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);
	localparam int Q_W = ACC_W - FRAC_SHIFT;

	logic signed [PROD_W-1:0]   prod_s1;
	logic                       vld_s1, first_s1, last_s1;
	dst_t                       dst_s1;
	logic signed [ACC_W-1:0]    acc_s2;
	logic                       done_s2;
	dst_t                       dst_s2;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    rnd_c;
	logic signed [Q_W-1:0]      q_c;
	logic signed [SAMPLE_W-1:0] sat_c;

	assign prod_c   = PROD_W'(req.coef) * PROD_W'(req.opd);
	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	// round half up, then floor shift: keep the upper bits of the biased sum
	assign rnd_c = acc_s2 + ROUND_BIAS;
	assign q_c   = rnd_c[ACC_W-1:FRAC_SHIFT];

	always_comb begin
		if (q_c[Q_W-1:SAMPLE_W-1] == '0 || q_c[Q_W-1:SAMPLE_W-1] == '1) begin
			sat_c = q_c[SAMPLE_W-1:0];
		end else if (q_c[Q_W-1]) begin
			sat_c = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1   <= '0;
			vld_s1    <= 1'b0;
			first_s1  <= 1'b0;
			last_s1   <= 1'b0;
			dst_s1    <= DST_YB;
			acc_s2    <= '0;
			done_s2   <= 1'b0;
			dst_s2    <= DST_YB;
			res       <= '0;
		end else begin
			prod_s1  <= prod_c;
			vld_s1   <= req.valid;
			first_s1 <= req.first;
			last_s1  <= req.last;
			dst_s1   <= req.dst;

			if (vld_s1) begin
				acc_s2 <= first_s1 ? prod_ext : acc_s2 + prod_ext;
			end
			done_s2 <= vld_s1 && last_s1;
			dst_s2  <= dst_s1;

			res.valid <= done_s2;
			res.dst   <= dst_s2;
			res.value <= sat_c;
		end
	end
endmodule
`default_nettype wire
